### sv/flk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flk_pkg
// Shared types and codes for the filter lock arbiter.
// ----------------------------------------------------------------------------
package flk_pkg;

  localparam int DefThreads = 8;
  localparam int MaxSlots   = 8;
  localparam logic [3:0] CountReset = 4'd8;

  typedef enum logic [1:0] {
    ActRequest = 2'd0,
    ActPoll    = 2'd1,
    ActRelease = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    StsIdle     = 3'd0,
    StsWaiting  = 3'd1,
    StsAdvanced = 3'd2,
    StsGranted  = 3'd3,
    StsReleased = 3'd4,
    StsRejected = 3'd5
  } status_e;

  typedef enum logic {
    FsmIdle = 1'b0,
    FsmEval = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] thread;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] thread_level;
  } out_t;

  typedef struct packed {
    logic load;
    logic eval;
  } cmd_t;

endpackage

### sv/flk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flk_ctrl
// Sequencer: latch an item, evaluate it in the next cycle.
// ----------------------------------------------------------------------------
module flk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output flk_pkg::cmd_t cmd_o
);

  flk_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flk_pkg::FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.eval = 1'b0;
    busy       = 1'b0;
    unique case (state_q)
      flk_pkg::FsmIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = flk_pkg::FsmEval;
        end
      end
      flk_pkg::FsmEval: begin
        busy       = 1'b1;
        cmd_o.eval = 1'b1;
        state_d    = flk_pkg::FsmIdle;
      end
      default: state_d = flk_pkg::FsmIdle;
    endcase
  end

endmodule

### sv/flk_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flk_datapath
// Lock state (levels, victims, owner marks), level check and result register.
// ----------------------------------------------------------------------------
module flk_datapath #(
  parameter int THREADS = flk_pkg::DefThreads
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  flk_pkg::cmd_t cmd_i,
  input  flk_pkg::in_t  item_i,
  input  logic          cfg_valid_i,
  input  logic [3:0]    cfg_data_i,
  output logic          result_strobe_o,
  output flk_pkg::out_t result_o
);

  localparam int Slots = (THREADS < flk_pkg::MaxSlots) ? THREADS : flk_pkg::MaxSlots;
  localparam int IdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [3:0] CountCap = 4'(Slots);

  logic [3:0]      count_q;
  flk_pkg::in_t    item_q;
  logic [2:0]      level_q  [Slots];
  logic [2:0]      victim_q [Slots];
  logic [Slots-1:0] owner_q;
  flk_pkg::out_t   result_q, result_d;
  logic            strobe_q;

  logic [3:0]      n;
  logic            bad;
  logic [IdxW-1:0] t_idx;
  logic [2:0]      lvl;
  logic [2:0]      lvl_up;
  logic            others;
  logic            blocked;
  logic            wr_level, wr_victim, wr_owner, owner_val;
  logic [2:0]      level_val;
  logic [IdxW-1:0] victim_idx;

  always_comb begin
    if (count_q == 4'd0) begin
      n = 4'd1;
    end else if (count_q > CountCap) begin
      n = CountCap;
    end else begin
      n = count_q;
    end
    bad    = {1'b0, item_q.thread} >= n;
    t_idx  = item_q.thread[IdxW-1:0];
    lvl    = bad ? 3'd0 : level_q[t_idx];
    lvl_up = lvl + 3'd1;
    others = 1'b0;
    for (int k = 0; k < Slots; k++) begin
      if ((4'(k) < n) && (IdxW'(k) != t_idx) && (level_q[k] >= lvl)) begin
        others = 1'b1;
      end
    end
    blocked    = others && (victim_q[lvl[IdxW-1:0]] == item_q.thread);
    wr_level   = 1'b0;
    level_val  = 3'd0;
    wr_victim  = 1'b0;
    victim_idx = lvl_up[IdxW-1:0];
    wr_owner   = 1'b0;
    owner_val  = 1'b0;
    result_d.status       = flk_pkg::StsRejected;
    result_d.thread_level = lvl;
    if (!bad) begin
      case (item_q.action)
        flk_pkg::ActRequest: begin
          if (owner_q[t_idx] || lvl != 3'd0) begin
            result_d.status = flk_pkg::StsRejected;
          end else if (n == 4'd1) begin
            wr_owner              = 1'b1;
            owner_val             = 1'b1;
            result_d.status       = flk_pkg::StsGranted;
            result_d.thread_level = 3'd0;
          end else begin
            wr_level              = 1'b1;
            level_val             = 3'd1;
            wr_victim             = 1'b1;
            victim_idx            = IdxW'(1);
            result_d.status       = flk_pkg::StsWaiting;
            result_d.thread_level = 3'd1;
          end
        end
        flk_pkg::ActPoll: begin
          if (owner_q[t_idx]) begin
            result_d.status = flk_pkg::StsGranted;
          end else if (lvl == 3'd0) begin
            result_d.status = flk_pkg::StsIdle;
          end else if (blocked) begin
            result_d.status = flk_pkg::StsWaiting;
          end else if (({1'b0, lvl} + 4'd1) >= n) begin
            wr_owner        = 1'b1;
            owner_val       = 1'b1;
            result_d.status = flk_pkg::StsGranted;
          end else begin
            wr_level              = 1'b1;
            level_val             = lvl_up;
            wr_victim             = 1'b1;
            victim_idx            = lvl_up[IdxW-1:0];
            result_d.status       = flk_pkg::StsAdvanced;
            result_d.thread_level = lvl_up;
          end
        end
        flk_pkg::ActRelease: begin
          result_d.thread_level = 3'd0;
          if (owner_q[t_idx] || lvl != 3'd0) begin
            wr_owner        = 1'b1;
            owner_val       = 1'b0;
            wr_level        = 1'b1;
            level_val       = 3'd0;
            result_d.status = flk_pkg::StsReleased;
          end else begin
            result_d.status = flk_pkg::StsIdle;
          end
        end
        default: result_d.status = flk_pkg::StsRejected;
      endcase
    end else begin
      result_d.thread_level = 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.eval) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= flk_pkg::CountReset;
      strobe_q <= 1'b0;
      owner_q  <= '0;
      for (int k = 0; k < Slots; k++) begin
        level_q[k]  <= 3'd0;
        victim_q[k] <= 3'd0;
      end
    end else begin
      strobe_q <= cmd_i.eval;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.eval) begin
        if (wr_level) begin
          level_q[t_idx] <= level_val;
        end
        if (wr_victim) begin
          victim_q[victim_idx] <= item_q.thread;
        end
        if (wr_owner) begin
          owner_q[t_idx] <= owner_val;
        end
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

### sv/filter_lock_arbiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filter_lock_arbiter_unit
// Filter lock (n-thread Peterson) arbiter: request, poll and release items.
// ----------------------------------------------------------------------------
// Start latches the item; evaluate then registers the result and its strobe.
// The latch-then-evaluate sequencer takes no new item while it evaluates one.
// busy is high during the evaluate cycle; the next start is taken with the strobe.
// Reset clears all levels, victims and owner marks and sets thread_count to 8.
// Results are strobed for one cycle; the receiver cannot stall.
module filter_lock_arbiter_unit #(
  parameter int THREADS = flk_pkg::DefThreads
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  flk_pkg::in_t  item_i,
  output logic          result_strobe_o,
  output flk_pkg::out_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_data_i
);

  flk_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  flk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  flk_datapath #(
    .THREADS (THREADS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_i          (item_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter evaluation");

  a_busy_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_strobe_o && !busy))
    else $error("evaluation produced no result strobe");

  a_strobe_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result strobe without evaluation");

  a_status_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (result_o.status <= flk_pkg::StsRejected))
    else $error("status code out of range");

endmodule
